// ----- src/ssm_pkg.sv -----
`default_nettype none

package ssm_pkg;

    localparam int MAX_NEEDLE_DEF = 32;
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 6;
    localparam int NEEDLE_WORDS   = 4;
    localparam int WORD_W         = 64;
    localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LEN = 3'd0,
        REG_WORD_0     = 3'd1,
        REG_WORD_1     = 3'd2,
        REG_WORD_2     = 3'd3,
        REG_WORD_3     = 3'd4
    } t_cfg_reg;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic adv;   // a haystack beat is accepted this cycle
        logic clr;   // restart the search, drop all partial matches
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- src/ssm_cell.sv -----
`default_nettype none

module ssm_cell
    import ssm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [BYTE_W-1:0] i_needle_byte,
    input  wire logic              i_prev_match,
    output logic                   o_match,
    output logic                   o_hit
);

    logic r_match;

    // The needle prefix that ends here matches if the shorter prefix matched
    // one beat earlier and this byte equals our needle byte.
    assign o_hit   = i_prev_match & (i_byte == i_needle_byte);
    assign o_match = r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.clr) begin
            r_match <= 1'b0;
        end else if (i_ctl.adv) begin
            r_match <= o_hit;
        end
    end

endmodule

`default_nettype wire

// ----- src/ssm_out_buf.sv -----
`default_nettype none

module ssm_out_buf (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire logic i_data,
    output logic      o_ready,
    output logic      o_valid,
    output logic      o_data,
    input  wire logic i_ready
);

    logic r_out_valid;
    logic r_out_data;
    logic r_skid_valid;
    logic r_skid_data;
    logic w_pop;

    assign w_pop   = r_out_valid & i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= i_push;
                r_skid_data  <= i_data;
            end else begin
                r_out_valid <= i_push;
                r_out_data  <= i_data;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= i_push;
            r_out_data  <= i_data;
        end else if (i_push) begin
            // The output beat is stalled, park the new result.
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/streaming_substring_match.sv -----
// Streaming substring matcher.
// Haystack bytes enter on the s_axis channel, one byte per beat in tdata[7:0].
// For every accepted byte one result beat leaves on m_axis: tdata[0] is 1 when
// that byte completes an occurrence of the needle; overlapping occurrences all
// count. The needle (up to MAX_NEEDLE bytes) and its length are written on the
// cfg channel; index 0 is the length, indexes 1 to 4 are the needle words.
// A write to a known index restarts the search; other indexes are ignored.
// A length of zero acts as one, a length above MAX_NEEDLE as MAX_NEEDLE.
// The search runs in a chain of MAX_NEEDLE cells; cell i holds whether the
// first i+1 needle bytes matched the most recent bytes. Each byte is compared
// in all cells at once, so one byte is taken every cycle while s_axis tready
// is high; its result is registered in the output buffer and leaves on m_axis.
// A two-entry output buffer lets the input keep flowing for one beat while
// the receiver stalls; after that s_axis tready drops until a beat is taken.
// Reset empties the output buffer, clears all partial matches, sets the
// length to one and the needle to zeros.
`default_nettype none

module streaming_substring_match
    import ssm_pkg::*;
#(
    parameter int MAX_NEEDLE = MAX_NEEDLE_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [BYTE_W-1:0]    i_s_axis_tdata,   // [7:0] hay_byte
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [BYTE_W-1:0]         o_m_axis_tdata,   // [0] match_found, [7:1] zero
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    localparam int LenW = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

    logic [LenW-1:0]     r_len_m1;
    logic [WORD_W-1:0]   r_needle_word [NEEDLE_WORDS];
    logic [LEN_W-1:0]    w_len_field;
    logic [LenW-1:0]     w_len_m1;
    logic                w_cfg_wr;
    logic                w_cfg_known;
    logic                w_in_acc;
    t_cell_ctl           w_ctl;
    logic [MAX_NEEDLE-1:0] w_match;
    logic [MAX_NEEDLE-1:0] w_hit;
    logic                w_out_data;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign w_in_acc    = i_s_axis_tvalid & o_s_axis_tready;
    assign w_len_field = i_cfg_data[LEN_W-1:0];

    always_comb begin
        case (t_cfg_reg'(i_cfg_index))
            REG_NEEDLE_LEN, REG_WORD_0, REG_WORD_1,
            REG_WORD_2, REG_WORD_3: w_cfg_known = 1'b1;
            default:                w_cfg_known = 1'b0;
        endcase
    end

    always_comb begin
        if (w_len_field == '0) begin
            w_len_m1 = '0;
        end else if (w_len_field > LEN_W'(MAX_NEEDLE)) begin
            w_len_m1 = LenW'(MAX_NEEDLE - 1);
        end else begin
            w_len_m1 = LenW'(w_len_field - LEN_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_m1 <= '0;
            for (int w = 0; w < NEEDLE_WORDS; w++) begin
                r_needle_word[w] <= '0;
            end
        end else if (w_cfg_wr) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_NEEDLE_LEN: r_len_m1         <= w_len_m1;
                REG_WORD_0:     r_needle_word[0] <= i_cfg_data;
                REG_WORD_1:     r_needle_word[1] <= i_cfg_data;
                REG_WORD_2:     r_needle_word[2] <= i_cfg_data;
                REG_WORD_3:     r_needle_word[3] <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    assign w_ctl.clr = w_cfg_wr & w_cfg_known;
    assign w_ctl.adv = w_in_acc;

    for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_cell
        logic w_prev;
        if (i == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_link
            assign w_prev = w_match[i-1];
        end

        ssm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_byte        (i_s_axis_tdata),
            .i_needle_byte (r_needle_word[i / BYTES_PER_WORD]
                                         [(i % BYTES_PER_WORD) * BYTE_W +: BYTE_W]),
            .i_prev_match  (w_prev),
            .o_match       (w_match[i]),
            .o_hit         (w_hit[i])
        );
    end

    ssm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_acc),
        .i_data  (w_hit[r_len_m1]),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out_data),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {{(BYTE_W-1){1'b0}}, w_out_data};

    // A restart leaves no partial match behind.
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr && w_cfg_known |=> w_match == '0)
        else $error("partial matches survive a restart");

    // The input only stalls while a result beat is pending.
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no output pending");

    // The first cell tracks a one-byte comparison with needle byte zero.
    a_head_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !w_cfg_wr |=>
            w_match[0] == ($past(i_s_axis_tdata) == r_needle_word[0][BYTE_W-1:0]))
        else $error("head cell disagrees with the last accepted byte");

    // The selected length always names an existing cell.
    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len_m1) < MAX_NEEDLE)
        else $error("needle length beyond the cell chain");

endmodule

`default_nettype wire
